// ===== rtl/pcnu_pkg.sv =====
`timescale 1ns / 1ps
package pcnu_pkg;

  localparam int PROB_W = 16;
  localparam int SUM_W  = 17;
  localparam int ACC_W  = 55;
  localparam int DIV_STEPS = 16;
  localparam logic [PROB_W-1:0] QUARTER = 16'd16384;

  typedef enum logic [0:0] {
    KIND_X = 1'b0,
    KIND_Z = 1'b1
  } check_kind_t;

  typedef struct packed {
    logic [1:0]       count;
    logic             kind;
    logic             syndrome;
  } close_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_E,
    BK_MUL_O,
    BK_DIV_C,
    BK_DIV_A,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic [1:0]       qubit_index;
    logic [PROB_W-1:0] out_i;
    logic [PROB_W-1:0] out_z;
    logic [PROB_W-1:0] out_x;
    logic [PROB_W-1:0] out_y;
    logic             degenerate;
    logic             last_out;
  } result_t;

endpackage

// ===== rtl/pcnu_front.sv =====
`timescale 1ns / 1ps
module pcnu_front #(
  parameter int MAX_WEIGHT = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pcnu_pkg::PROB_W-1:0] prob_i,
  input  logic [pcnu_pkg::PROB_W-1:0] prob_z,
  input  logic [pcnu_pkg::PROB_W-1:0] prob_x,
  input  logic [pcnu_pkg::PROB_W-1:0] prob_y,
  input  logic                      kind,
  input  logic                      syndrome,
  input  logic                      last,
  input  logic                      back_busy,
  output logic                      cmd_valid,
  output pcnu_pkg::close_cmd_t      cmd,
  output logic [pcnu_pkg::SUM_W-1:0] csum [MAX_WEIGHT],
  output logic [pcnu_pkg::SUM_W-1:0] asum [MAX_WEIGHT]
);
  import pcnu_pkg::*;

  localparam int IDX_W = $clog2(MAX_WEIGHT);
  localparam int CNT_W = $clog2(MAX_WEIGHT + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] csum_r [MAX_WEIGHT];
  logic [SUM_W-1:0] asum_r [MAX_WEIGHT];
  logic             cmd_valid_r, cmd_valid_nxt;
  close_cmd_t       cmd_r, cmd_nxt;
  logic             accept, store;
  logic [SUM_W-1:0] c_new, a_new;

  assign in_ready = !back_busy && !cmd_valid_r;
  assign accept   = in_valid && in_ready;
  assign store    = accept && (count_r < CNT_W'(MAX_WEIGHT));

  always_comb begin
    if (kind == KIND_X) begin
      c_new = {1'b0, prob_i} + {1'b0, prob_x};
      a_new = {1'b0, prob_z} + {1'b0, prob_y};
    end else begin
      c_new = {1'b0, prob_i} + {1'b0, prob_z};
      a_new = {1'b0, prob_x} + {1'b0, prob_y};
    end
  end

  always_comb begin
    count_nxt     = count_r;
    cmd_valid_nxt = cmd_valid_r;
    cmd_nxt       = cmd_r;
    if (cmd_valid_r) cmd_valid_nxt = 1'b0;
    if (accept) begin
      if (store) count_nxt = count_r + CNT_W'(1);
      if (last) begin
        cmd_valid_nxt    = 1'b1;
        cmd_nxt.count    = 2'((store ? count_r + CNT_W'(1) : count_r) - CNT_W'(1));
        cmd_nxt.kind     = kind;
        cmd_nxt.syndrome = syndrome;
        count_nxt        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmd_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cmd_valid_r <= cmd_valid_nxt;
    end
    cmd_r <= cmd_nxt;
    if (store) begin
      csum_r[count_r[IDX_W-1:0]] <= c_new;
      asum_r[count_r[IDX_W-1:0]] <= a_new;
    end
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;
  assign csum      = csum_r;
  assign asum      = asum_r;
endmodule

// ===== rtl/pcnu_back.sv =====
`timescale 1ns / 1ps
module pcnu_back #(
  parameter int MAX_WEIGHT = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  pcnu_pkg::close_cmd_t       cmd,
  input  logic [pcnu_pkg::SUM_W-1:0] csum [MAX_WEIGHT],
  input  logic [pcnu_pkg::SUM_W-1:0] asum [MAX_WEIGHT],
  output logic                       busy,
  output logic                       res_valid,
  input  logic                       res_ready,
  output pcnu_pkg::result_t          res
);
  import pcnu_pkg::*;

  localparam int IDX_W = $clog2(MAX_WEIGHT);

  back_state_t       state_r, state_nxt;
  close_cmd_t        cmd_r, cmd_nxt;
  logic [1:0]        b_r, b_nxt, q_r, q_nxt;
  logic [ACC_W-1:0]  ev_r, ev_nxt, od_r, od_nxt;
  logic [ACC_W-1:0]  pe_r, pe_nxt;
  logic [ACC_W:0]    rem_r, rem_nxt, den_r, den_nxt;
  logic [4:0]        step_r, step_nxt;
  logic [PROB_W-1:0] quo_r, quo_nxt, oc_r, oc_nxt;
  logic              res_valid_r, res_valid_nxt;
  result_t           res_r, res_nxt;
  logic [SUM_W-1:0]  c_q, a_q;
  logic [SUM_W-1:0]  ev_op, od_op;
  logic [ACC_W-1:0]  mac;
  logic [ACC_W:0]    r2, vsel;
  logic              skip, q_end, degen;
  logic [PROB_W-1:0] oa_v;

  assign c_q   = csum[q_r[IDX_W-1:0]];
  assign a_q   = asum[q_r[IDX_W-1:0]];
  assign skip  = (q_r == b_r);
  assign q_end = (q_r == cmd_r.count);
  assign r2    = {rem_r[ACC_W-1:0], 1'b0};
  assign degen = (den_r == '0);

  // even weight takes c/a in MUL_E, odd weight takes a/c in MUL_O
  assign ev_op = (state_r == BK_MUL_E) ? c_q : a_q;
  assign od_op = (state_r == BK_MUL_E) ? a_q : c_q;
  assign mac   = ACC_W'(ev_r * ev_op + od_r * od_op);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    b_nxt         = b_r;
    q_nxt         = q_r;
    ev_nxt        = ev_r;
    od_nxt        = od_r;
    pe_nxt        = pe_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    step_nxt      = step_r;
    quo_nxt       = quo_r;
    oc_nxt        = oc_r;
    res_valid_nxt = res_valid_r;
    res_nxt       = res_r;
    vsel          = '0;
    oa_v          = '0;
    if (res_valid_r && res_ready) res_valid_nxt = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt   = cmd;
          b_nxt     = '0;
          q_nxt     = '0;
          ev_nxt    = ACC_W'(1);
          od_nxt    = '0;
          state_nxt = BK_MUL_E;
        end
      end
      BK_MUL_E: begin
        if (skip) begin
          if (q_end) begin
            den_nxt   = {1'b0, ev_r} + {1'b0, od_r};
            state_nxt = BK_DIV_C;
            vsel      = {1'b0, cmd_r.syndrome ? od_r : ev_r};
            rem_nxt   = vsel;
            step_nxt  = '0;
            quo_nxt   = '0;
          end else begin
            q_nxt = q_r + 2'd1;
          end
        end else begin
          pe_nxt    = mac;
          state_nxt = BK_MUL_O;
        end
      end
      BK_MUL_O: begin
        od_nxt = mac;
        ev_nxt = pe_r;
        if (q_end) begin
          den_nxt   = {1'b0, pe_r} + {1'b0, od_nxt};
          state_nxt = BK_DIV_C;
          rem_nxt   = {1'b0, cmd_r.syndrome ? od_nxt : pe_r};
          step_nxt  = '0;
          quo_nxt   = '0;
        end else begin
          q_nxt     = q_r + 2'd1;
          state_nxt = BK_MUL_E;
        end
      end
      BK_DIV_C, BK_DIV_A: begin
        if (step_r == '0) begin
          if (rem_r >= den_r && !degen) begin
            rem_nxt = rem_r - den_r;
            quo_nxt = 16'd1;
          end
          step_nxt = 5'd1;
        end else begin
          if (r2 >= den_r) begin
            rem_nxt = r2 - den_r;
            quo_nxt = {quo_r[PROB_W-2:0], 1'b1};
          end else begin
            rem_nxt = r2;
            quo_nxt = {quo_r[PROB_W-2:0], 1'b0};
          end
          step_nxt = step_r + 5'd1;
          if (step_r == 5'(DIV_STEPS - 1)) begin
            if (state_r == BK_DIV_C) begin
              oc_nxt    = quo_nxt;
              rem_nxt   = {1'b0, cmd_r.syndrome ? ev_r : od_r};
              step_nxt  = '0;
              quo_nxt   = '0;
              state_nxt = BK_DIV_A;
            end else begin
              state_nxt = BK_OUT;
            end
          end
        end
      end
      BK_OUT: begin
        if (!res_valid_r || res_ready) begin
          oa_v = degen ? QUARTER : quo_r;
          res_nxt.qubit_index = b_r;
          res_nxt.out_i       = degen ? QUARTER : oc_r;
          res_nxt.out_z       = (cmd_r.kind == KIND_X) ? oa_v : res_nxt.out_i;
          res_nxt.out_x       = (cmd_r.kind == KIND_X) ? res_nxt.out_i : oa_v;
          res_nxt.out_y       = oa_v;
          res_nxt.degenerate  = degen;
          res_nxt.last_out    = (b_r == cmd_r.count);
          res_valid_nxt       = 1'b1;
          if (b_r == cmd_r.count) begin
            state_nxt = BK_IDLE;
          end else begin
            b_nxt     = b_r + 2'd1;
            q_nxt     = '0;
            ev_nxt    = ACC_W'(1);
            od_nxt    = '0;
            state_nxt = BK_MUL_E;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
    cmd_r  <= cmd_nxt;
    b_r    <= b_nxt;
    q_r    <= q_nxt;
    ev_r   <= ev_nxt;
    od_r   <= od_nxt;
    pe_r   <= pe_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    oc_r   <= oc_nxt;
    res_r  <= res_nxt;
  end

  assign busy      = (state_r != BK_IDLE) || res_valid_r;
  assign res_valid = res_valid_r;
  assign res       = res_r;
endmodule

// ===== rtl/pauli_check_node_update_core.sv =====
`timescale 1ns / 1ps
// channel  | handshake            | payload
// in_      | in_valid / in_ready  | prob_i prob_z prob_x prob_y kind syndrome last
// out_     | out_valid / out_ready| qubit_index out_i out_z out_x out_y degenerate last_out
// Loading: one message per cycle while in_ready is high; the last message registers
// a close command for the back end. Per result, the back end multiplies over the
// other qubits of the check, then runs two 16-bit long divisions and an output step.
// The divider (one quotient bit a cycle) sets the rate unless the output stalls.
// Reset: rst_n synchronous, active low; clears counts, state and valid flags only.
// Input stalls while a check is being closed and emitted; output holds until taken.
module pauli_check_node_update_core #(
  parameter int MAX_WEIGHT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_prob_i,
  input  logic [15:0] in_prob_z,
  input  logic [15:0] in_prob_x,
  input  logic [15:0] in_prob_y,
  input  logic        in_kind,
  input  logic        in_syndrome,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_qubit_index,
  output logic [15:0] out_i,
  output logic [15:0] out_z,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic        out_degenerate,
  output logic        out_last_out
);
  import pcnu_pkg::*;

  logic             cmd_valid, back_busy;
  close_cmd_t       cmd;
  logic [SUM_W-1:0] csum [MAX_WEIGHT];
  logic [SUM_W-1:0] asum [MAX_WEIGHT];
  result_t          res;

  pcnu_front #(.MAX_WEIGHT(MAX_WEIGHT)) u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .prob_i(in_prob_i), .prob_z(in_prob_z), .prob_x(in_prob_x), .prob_y(in_prob_y),
    .kind(in_kind), .syndrome(in_syndrome), .last(in_last),
    .back_busy, .cmd_valid, .cmd, .csum, .asum
  );

  pcnu_back #(.MAX_WEIGHT(MAX_WEIGHT)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .csum, .asum,
    .busy(back_busy), .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign out_qubit_index = res.qubit_index;
  assign out_i           = res.out_i;
  assign out_z           = res.out_z;
  assign out_x           = res.out_x;
  assign out_y           = res.out_y;
  assign out_degenerate  = res.degenerate;
  assign out_last_out    = res.last_out;
endmodule

// ===== rtl/pcnu_checker.sv =====
`timescale 1ns / 1ps
module pcnu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_i,
  input logic        out_degenerate,
  input logic        out_last_out
);
  a_no_in_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready) else $error("input taken after close");
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input open during emission");
  a_degen_quarter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_i == 16'd16384) else $error("degenerate value");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last_out))
    else $error("output dropped");
endmodule

bind pauli_check_node_update_core pcnu_checker u_checker (
  .clk, .rst_n, .in_valid, .in_ready, .in_last, .out_valid, .out_ready,
  .out_i, .out_degenerate, .out_last_out
);
